>>> rtl/core/tpb_pkg.sv
// Shared types and constants of the turtle plotter bitmap block.
package tpb_pkg;

  localparam int ROWS      = 32;
  localparam int COLS      = 32;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int COL_W     = $clog2(COLS);
  localparam int DISP_ROWS = (ROWS < 32) ? ROWS : 32;
  localparam int DISP_W    = (COLS < 32) ? COLS : 32;

  localparam int OP_W      = 3;
  localparam int DIST_W    = 8;
  localparam int IDX_W     = 5;
  localparam int BITS_W    = 32;

  typedef enum logic [OP_W-1:0] {
    OP_PEN_UP   = 3'd0,
    OP_PEN_DOWN = 3'd1,
    OP_TURN_R   = 3'd2,
    OP_TURN_L   = 3'd3,
    OP_MOVE     = 3'd4,
    OP_DISPLAY  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    HEAD_N = 2'd0,
    HEAD_E = 2'd1,
    HEAD_S = 2'd2,
    HEAD_W = 2'd3
  } head_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE,
    ST_MARK,
    ST_DISP_RD,
    ST_DISP_LD
  } st_e;

endpackage

>>> rtl/core/tpb_cmd_if.sv
// Command channel carrying one turtle command per item.
interface tpb_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [tpb_pkg::OP_W-1:0]   opcode;
  logic [tpb_pkg::DIST_W-1:0] distance;

  modport source (output valid, output opcode, output distance, input ready);
  modport sink (input valid, input opcode, input distance, output ready);
endinterface

>>> rtl/core/tpb_row_if.sv
// Row channel carrying one displayed floor row per item.
interface tpb_row_if;
  logic                       valid;
  logic                       ready;
  logic [tpb_pkg::IDX_W-1:0]  row_index;
  logic [tpb_pkg::BITS_W-1:0] row_bits;
  logic                       last_row;

  modport source (output valid, output row_index, output row_bits, output last_row,
                  input ready);
  modport sink (input valid, input row_index, input row_bits, input last_row,
                output ready);
endinterface

>>> rtl/core/turtle_plotter_bitmap_core.sv
// Top level of the turtle plotter bitmap block: sequencer, floor memory and row output.
//
// One command is taken at a time; cmd_i.ready is high only while the sequencer is idle.
// Pen and turn commands complete in the idle state. A move steps one cell at a time; with
// the pen down each marked cell is a read-modify-write of its row in the single-port floor
// memory, read in ST_MOVE and written in ST_MARK; the distance is clipped at the floor edge
// before stepping starts. A display reads the floor row by row, a read in ST_DISP_RD and a
// load of the output register in ST_DISP_LD, which waits while the row channel stalls.
// Reset clears the floor at once through one valid bit per row; no clearing pass is needed.
module turtle_plotter_bitmap_core (
  input  logic clk_i,
  input  logic rst_ni,
  tpb_cmd_if.sink   cmd_i,
  tpb_row_if.source row_o
);

  localparam logic [tpb_pkg::DIST_W-1:0] RowLast = tpb_pkg::DIST_W'(tpb_pkg::ROWS - 1);
  localparam logic [tpb_pkg::DIST_W-1:0] ColLast = tpb_pkg::DIST_W'(tpb_pkg::COLS - 1);
  localparam logic [tpb_pkg::ROW_W-1:0]  DispLast =
    tpb_pkg::ROW_W'(tpb_pkg::DISP_ROWS - 1);

  tpb_pkg::st_e state_q, state_d;
  tpb_pkg::head_e heading_q, heading_d;
  logic pen_q, pen_d;
  logic [tpb_pkg::ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [tpb_pkg::COL_W-1:0]  cur_col_q, cur_col_d;
  logic [tpb_pkg::DIST_W-1:0] steps_q, steps_d;
  logic [tpb_pkg::ROW_W-1:0]  disp_q, disp_d;

  logic [tpb_pkg::DISP_W-1:0] floor_mem [tpb_pkg::ROWS];
  logic [tpb_pkg::ROWS-1:0]   row_vld_q;
  logic [tpb_pkg::DISP_W-1:0] rd_data_q;
  logic                       rd_vld_q;
  logic                       mem_rd;
  logic [tpb_pkg::ROW_W-1:0]  mem_addr;
  logic                       mem_we;
  logic [tpb_pkg::DISP_W-1:0] mem_wdata;

  logic                       out_vld_q, out_vld_d;
  logic [tpb_pkg::ROW_W-1:0]  out_idx_q, out_idx_d;
  logic [tpb_pkg::DISP_W-1:0] out_bits_q, out_bits_d;
  logic                       out_last_q, out_last_d;

  logic                       accept;
  logic [tpb_pkg::DIST_W-1:0] room;
  logic [tpb_pkg::DIST_W-1:0] clip_dist;
  logic                       out_free;
  tpb_pkg::op_e               op;

  assign accept   = cmd_i.valid && cmd_i.ready;
  assign op       = tpb_pkg::op_e'(cmd_i.opcode);
  assign out_free = !out_vld_q || row_o.ready;

  always_comb begin
    case (heading_q)
      tpb_pkg::HEAD_N: room = tpb_pkg::DIST_W'(cur_row_q);
      tpb_pkg::HEAD_S: room = RowLast - tpb_pkg::DIST_W'(cur_row_q);
      tpb_pkg::HEAD_E: room = ColLast - tpb_pkg::DIST_W'(cur_col_q);
      default:         room = tpb_pkg::DIST_W'(cur_col_q);
    endcase
    clip_dist = (cmd_i.distance > room) ? room : cmd_i.distance;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tpb_pkg::ST_IDLE: begin
        if (accept && op == tpb_pkg::OP_MOVE) begin
          state_d = tpb_pkg::ST_MOVE;
        end else if (accept && op == tpb_pkg::OP_DISPLAY) begin
          state_d = tpb_pkg::ST_DISP_RD;
        end
      end
      tpb_pkg::ST_MOVE: begin
        if (steps_q == '0) begin
          state_d = tpb_pkg::ST_IDLE;
        end else if (pen_q) begin
          state_d = tpb_pkg::ST_MARK;
        end
      end
      tpb_pkg::ST_MARK:    state_d = tpb_pkg::ST_MOVE;
      tpb_pkg::ST_DISP_RD: state_d = tpb_pkg::ST_DISP_LD;
      tpb_pkg::ST_DISP_LD: begin
        if (out_free) begin
          state_d = (disp_q == DispLast) ? tpb_pkg::ST_IDLE : tpb_pkg::ST_DISP_RD;
        end
      end
      default: state_d = tpb_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    heading_d  = heading_q;
    pen_d      = pen_q;
    cur_row_d  = cur_row_q;
    cur_col_d  = cur_col_q;
    steps_d    = steps_q;
    disp_d     = disp_q;
    mem_rd     = 1'b0;
    mem_addr   = cur_row_q;
    mem_we     = 1'b0;
    mem_wdata  = (rd_vld_q ? rd_data_q : '0) | (tpb_pkg::DISP_W'(1) << cur_col_q);
    out_vld_d  = out_vld_q && !row_o.ready;
    out_idx_d  = out_idx_q;
    out_bits_d = out_bits_q;
    out_last_d = out_last_q;
    cmd_i.ready = (state_q == tpb_pkg::ST_IDLE);

    case (state_q)
      tpb_pkg::ST_IDLE: begin
        if (accept) begin
          case (op)
            tpb_pkg::OP_PEN_UP:   pen_d = 1'b0;
            tpb_pkg::OP_PEN_DOWN: pen_d = 1'b1;
            tpb_pkg::OP_TURN_R:   heading_d = tpb_pkg::head_e'(heading_q + 2'd1);
            tpb_pkg::OP_TURN_L:   heading_d = tpb_pkg::head_e'(heading_q - 2'd1);
            tpb_pkg::OP_MOVE:     steps_d = clip_dist;
            tpb_pkg::OP_DISPLAY:  disp_d = '0;
            default: ;
          endcase
        end
      end
      tpb_pkg::ST_MOVE, tpb_pkg::ST_MARK: begin
        if (state_q == tpb_pkg::ST_MOVE && steps_q != '0 && pen_q) begin
          mem_rd = 1'b1;
        end
        if (state_q == tpb_pkg::ST_MARK) begin
          mem_we = 1'b1;
        end
        if ((state_q == tpb_pkg::ST_MOVE && steps_q != '0 && !pen_q) ||
            state_q == tpb_pkg::ST_MARK) begin
          steps_d = steps_q - 1'b1;
          case (heading_q)
            tpb_pkg::HEAD_N: cur_row_d = cur_row_q - 1'b1;
            tpb_pkg::HEAD_S: cur_row_d = cur_row_q + 1'b1;
            tpb_pkg::HEAD_E: cur_col_d = cur_col_q + 1'b1;
            default:         cur_col_d = cur_col_q - 1'b1;
          endcase
        end
      end
      tpb_pkg::ST_DISP_RD: begin
        mem_rd   = 1'b1;
        mem_addr = disp_q;
      end
      tpb_pkg::ST_DISP_LD: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_idx_d  = disp_q;
          out_bits_d = rd_vld_q ? rd_data_q : '0;
          out_last_d = (disp_q == DispLast);
          disp_d     = disp_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign row_o.valid     = out_vld_q;
  assign row_o.row_index = tpb_pkg::IDX_W'(out_idx_q);
  assign row_o.row_bits  = tpb_pkg::BITS_W'(out_bits_q);
  assign row_o.last_row  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tpb_pkg::ST_IDLE;
      heading_q <= tpb_pkg::HEAD_E;
      pen_q     <= 1'b0;
      cur_row_q <= '0;
      cur_col_q <= '0;
      steps_q   <= '0;
      disp_q    <= '0;
      out_vld_q <= 1'b0;
      row_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      heading_q <= heading_d;
      pen_q     <= pen_d;
      cur_row_q <= cur_row_d;
      cur_col_q <= cur_col_d;
      steps_q   <= steps_d;
      disp_q    <= disp_d;
      out_vld_q <= out_vld_d;
      if (mem_we) begin
        row_vld_q[mem_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_idx_q  <= out_idx_d;
    out_bits_q <= out_bits_d;
    out_last_q <= out_last_d;
  end

  // Floor memory: one port, registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      floor_mem[mem_addr] <= mem_wdata;
    end
    if (mem_rd) begin
      rd_data_q <= floor_mem[mem_addr];
      rd_vld_q  <= row_vld_q[mem_addr];
    end
  end

endmodule
